// ===== rtl/ia_pkg.sv =====
package ia_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 7;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_DELETE = 3'd2,
    KIND_SEARCH = 3'd3,
    KIND_CHANGE = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // What a cell does with its word on this edge
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     probe;
    logic     live;
  } cell_ctl_t;

endpackage

// ===== rtl/ia_cell.sv =====
module ia_cell
  import ia_pkg::*;
(
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [WORD_W-1:0] left,
  input  logic signed [WORD_W-1:0] right,
  input  logic signed [WORD_W-1:0] value,
  output logic signed [WORD_W-1:0] word,
  output logic                     hit
);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_LOAD:  word <= value;
      CELL_LEFT:  word <= left;
      CELL_RIGHT: word <= right;
      default:    word <= word;
    endcase
    // capture the compare only for a search; an unoccupied entry never hits
    if (ctl.probe) begin
      hit <= ctl.live && (word == value);
    end
  end

endmodule

// ===== rtl/indexed_array_insert_delete_search.sv =====
// Append, insert, delete, change and unused kinds: result beat on the edge after acceptance.
// Search: compare registered in the cells, then OR of the hit row once the output is free.
// Throughput: one non-search item per cycle while results are taken; a search holds input until
// its result is loaded. Every cell shifts, loads or holds in parallel, so no operation iterates.
// Reset clears the entry count and both handshakes; entry words are undefined until written.
module indexed_array_insert_delete_search
  import ia_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [KIND_W-1:0]          kind,
  input  logic [POS_W-1:0]           position,
  input  logic signed [WORD_W-1:0]   value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        status,
  output logic                       found,
  output logic [COUNT_W-1:0]         count
);

  // width of the entry count, and a common width for position compares
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic {
    S_IDLE,
    S_SRCH
  } state_t;

  state_t          state;
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   cnt_next;
  status_t         status_c;
  logic            accept;
  logic            out_free;
  logic            pos_ok;
  logic            is_full;
  logic            do_app;
  logic            do_ins;
  logic            do_del;
  logic            do_chg;
  logic            probe;
  logic [LW-1:0]   pos_w;
  logic [LW-1:0]   cnt_w;

  logic signed [WORD_W-1:0] words [CAPACITY];
  logic [CAPACITY-1:0]      hits;

  // The output register frees the input side as soon as the pending beat is taken.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign pos_w   = LW'(position);
  assign cnt_w   = LW'(cnt);
  assign pos_ok  = (pos_w != '0) && (pos_w <= cnt_w);
  assign is_full = (cnt == CW'(CAPACITY));

  // Decode the operation: status, new count, and which edit the cell row performs.
  always_comb begin
    status_c = ST_OK;
    cnt_next = cnt;
    do_app   = 1'b0;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    do_chg   = 1'b0;
    case (kind)
      KIND_APPEND: begin
        if (is_full) begin
          status_c = ST_FULL;
        end else begin
          do_app   = 1'b1;
          cnt_next = cnt + CW'(1);
        end
      end
      KIND_INSERT: begin
        if (!pos_ok) begin
          status_c = ST_BADPOS;
        end else if (is_full) begin
          status_c = ST_FULL;
        end else begin
          do_ins   = 1'b1;
          cnt_next = cnt + CW'(1);
        end
      end
      KIND_DELETE: begin
        if (!pos_ok) begin
          status_c = ST_BADPOS;
        end else begin
          do_del   = 1'b1;
          cnt_next = cnt - CW'(1);
        end
      end
      KIND_SEARCH: begin
        status_c = ST_OK;
      end
      KIND_CHANGE: begin
        if (!pos_ok) begin
          status_c = ST_BADPOS;
        end else begin
          do_chg = 1'b1;
        end
      end
      default: begin
        status_c = ST_BADPOS;
      end
    endcase
  end

  assign probe = accept && (kind == KIND_SEARCH);

  // Row of cells: entry i sits at 1-based position i+1. Insert moves entries at and
  // above the position up (each cell takes its left neighbour), delete moves them
  // down (each cell takes its right neighbour).
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t                ctl;
    logic signed [WORD_W-1:0] left_w;
    logic signed [WORD_W-1:0] right_w;
    logic [LW-1:0]            here;

    assign here = LW'(i + 1);

    always_comb begin
      ctl.op    = CELL_HOLD;
      ctl.probe = probe;
      ctl.live  = (LW'(i) < cnt_w);
      if (accept) begin
        if (do_app && (LW'(i) == cnt_w)) begin
          ctl.op = CELL_LOAD;
        end else if ((do_ins || do_chg) && (here == pos_w)) begin
          ctl.op = CELL_LOAD;
        end else if (do_ins && (here > pos_w)) begin
          ctl.op = CELL_LEFT;
        end else if (do_del && (here >= pos_w)) begin
          ctl.op = CELL_RIGHT;
        end
      end
    end

    if (i == 0) begin : g_first
      assign left_w = value;
    end else begin : g_mid
      assign left_w = words[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = words[i];
    end else begin : g_inner
      assign right_w = words[i+1];
    end

    ia_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .left  (left_w),
      .right (right_w),
      .value (value),
      .word  (words[i]),
      .hit   (hits[i])
    );
  end

  // Control and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      status    <= ST_OK;
      found     <= 1'b0;
      count     <= '0;
    end else begin
      // drop the beat once the far side takes it
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (kind == KIND_SEARCH) begin
              state <= S_SRCH;
            end else begin
              out_valid <= 1'b1;
              status    <= status_c;
              found     <= 1'b0;
              count     <= COUNT_W'(cnt_next);
              cnt       <= cnt_next;
            end
          end
        end
        S_SRCH: begin
          // hit row is held in the cells; reduce it once the result register is free
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= ST_OK;
            found     <= |hits;
            count     <= COUNT_W'(cnt);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/ia_chk.sv =====
module ia_chk
  import ia_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [KIND_W-1:0]        kind,
  input logic [POS_W-1:0]         position,
  input logic signed [WORD_W-1:0] value,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [STATUS_W-1:0]      status,
  input logic                     found,
  input logic [COUNT_W-1:0]       count
);

  // a stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(kind) && $stable(position) && $stable(value))
    else $error("input beat changed while stalled");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(found) && $stable(count))
    else $error("result beat changed while stalled");

  // no new item while a result is waiting and held
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result register blocked");

  // found only comes with an ok status
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> status == ST_OK)
    else $error("found set on a failed operation");

  // full is reported only at capacity
  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> count == COUNT_W'(CAPACITY))
    else $error("full status below capacity");

endmodule

bind indexed_array_insert_delete_search ia_chk #(.CAPACITY(CAPACITY)) u_ia_chk (.*);
